// ----- hdl/pls_pkg.sv -----
package pls_pkg;

    // coordinate widths: targets are signed, positions are unsigned and one bit narrower
    localparam int COORD_BITS = 16;
    localparam int POS_BITS   = COORD_BITS - 1;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // request types
    localparam logic REQ_MOVE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_ACCEPTED = 3'd0;
    localparam logic [2:0] KIND_RANGE    = 3'd1;
    localparam logic [2:0] KIND_BUSY     = 3'd2;
    localparam logic [2:0] KIND_STEP     = 3'd3;
    localparam logic [2:0] KIND_IDLE     = 3'd4;

    // step directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Y = 1'b1;

    typedef struct packed {
        logic                         req_type;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic                         pen_down;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          result_kind;
        logic [1:0]          step_dir;
        logic                servo_cmd;
        logic                pen_state_out;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
        logic                move_done;
    } out_item_t;

    // classified item as it waits in the queue
    typedef struct packed {
        logic                is_tick;
        logic                in_range;
        logic [POS_BITS-1:0] tgt_x;
        logic [POS_BITS-1:0] tgt_y;
        logic                pen;
    } cmd_t;

endpackage

// ----- hdl/pls_front.sv -----
module pls_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [pls_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pls_pkg::POS_BITS-1:0]         cfg_data,
    input  logic                                 req_valid,
    input  pls_pkg::in_item_t                    req_data,
    input  logic                                 queue_full,
    output logic                                 req_stall,
    output logic                                 push_valid,
    output pls_pkg::cmd_t                        push_cmd
);
    import pls_pkg::*;

    logic [POS_BITS-1:0] max_x_reg;
    logic [POS_BITS-1:0] max_x_next;
    logic [POS_BITS-1:0] max_y_reg;
    logic [POS_BITS-1:0] max_y_next;
    logic                x_ok;
    logic                y_ok;

    // configuration writes
    always_comb
    begin
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_MAX_X: max_x_next = cfg_data;
                CFG_MAX_Y: max_y_next = cfg_data;
                default:   max_x_next = max_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= '1;
            max_y_reg <= '1;
        end
        else
        begin
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

    // range check on the signed target
    assign x_ok = !req_data.target_x[COORD_BITS-1]
                  && (req_data.target_x[POS_BITS-1:0] <= max_x_reg);
    assign y_ok = !req_data.target_y[COORD_BITS-1]
                  && (req_data.target_y[POS_BITS-1:0] <= max_y_reg);

    // classify and hand over to the queue
    assign push_valid        = req_valid;
    assign push_cmd.is_tick  = (req_data.req_type == REQ_TICK);
    assign push_cmd.in_range = x_ok && y_ok;
    assign push_cmd.tgt_x    = req_data.target_x[POS_BITS-1:0];
    assign push_cmd.tgt_y    = req_data.target_y[POS_BITS-1:0];
    assign push_cmd.pen      = req_data.pen_down;
    assign req_stall         = queue_full;

endmodule

// ----- hdl/pls_queue.sv -----
module pls_queue #(
    parameter int DEPTH = pls_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  pls_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          head_valid,
    output pls_pkg::cmd_t head_cmd,
    input  logic          pop
);
    import pls_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    cmd_t                entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == CNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // fill level and pointers agree
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue fill level beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with split pointers");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue fill level missed a push");

endmodule

// ----- hdl/pls_back.sv -----
module pls_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  pls_pkg::cmd_t      head_cmd,
    output logic               pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output pls_pkg::out_item_t rsp_data
);
    import pls_pkg::*;

    // motion state
    logic [POS_BITS-1:0]   cur_x_reg;
    logic [POS_BITS-1:0]   cur_x_next;
    logic [POS_BITS-1:0]   cur_y_reg;
    logic [POS_BITS-1:0]   cur_y_next;
    logic                  pen_reg;
    logic                  pen_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  x_neg_reg;
    logic                  x_neg_next;
    logic                  y_neg_reg;
    logic                  y_neg_next;
    logic [POS_BITS-1:0]   dy_reg;
    logic [POS_BITS-1:0]   dy_next;
    logic [POS_BITS-1:0]   div_reg;
    logic [POS_BITS-1:0]   div_next;
    logic [POS_BITS-1:0]   cols_reg;
    logic [POS_BITS-1:0]   cols_next;
    logic [COORD_BITS-1:0] acc_reg;
    logic [COORD_BITS-1:0] acc_next;
    logic                  vpend_reg;
    logic                  vpend_next;

    // result register
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    out_item_t             rsp_data_reg;
    out_item_t             rsp_data_next;

    // move setup terms
    logic                  x_ge;
    logic                  y_ge;
    logic [POS_BITS-1:0]   dx_abs;
    logic [POS_BITS-1:0]   dy_abs;
    logic                  dx_zero;
    logic                  take;

    assign take = head_valid && (!rsp_valid_reg || !rsp_stall);
    assign pop  = take;

    // distances to the target, both orders computed in parallel
    assign x_ge    = (head_cmd.tgt_x >= cur_x_reg);
    assign y_ge    = (head_cmd.tgt_y >= cur_y_reg);
    assign dx_abs  = x_ge ? (head_cmd.tgt_x - cur_x_reg) : (cur_x_reg - head_cmd.tgt_x);
    assign dy_abs  = y_ge ? (head_cmd.tgt_y - cur_y_reg) : (cur_y_reg - head_cmd.tgt_y);
    assign dx_zero = (dx_abs == '0);

    // execute one item
    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        pen_next   = pen_reg;
        busy_next  = busy_reg;
        x_neg_next = x_neg_reg;
        y_neg_next = y_neg_reg;
        dy_next    = dy_reg;
        div_next   = div_reg;
        cols_next  = cols_reg;
        acc_next   = acc_reg;
        vpend_next = vpend_reg;

        rsp_data_next               = rsp_data_reg;
        rsp_data_next.result_kind   = KIND_IDLE;
        rsp_data_next.step_dir      = DIR_UP;
        rsp_data_next.servo_cmd     = 1'b0;
        rsp_data_next.move_done     = 1'b0;

        if (!head_cmd.is_tick)
        begin
            if (busy_reg)
            begin
                rsp_data_next.result_kind = KIND_BUSY;
            end
            else
            begin
                // pen follows the request even when the target is rejected
                if (head_cmd.pen != pen_reg)
                begin
                    rsp_data_next.servo_cmd = 1'b1;
                    pen_next                = head_cmd.pen;
                end
                if (!head_cmd.in_range)
                begin
                    rsp_data_next.result_kind = KIND_RANGE;
                end
                else
                begin
                    rsp_data_next.result_kind = KIND_ACCEPTED;
                    x_neg_next = !x_ge;
                    y_neg_next = !y_ge;
                    dy_next    = dy_abs;
                    cols_next  = dx_abs;
                    // a pure vertical move counts down dy against a divisor of one
                    div_next   = dx_zero ? POS_BITS'(1) : dx_abs;
                    acc_next   = dx_zero ? {1'b0, dy_abs} : '0;
                    vpend_next = dx_zero && (dy_abs != '0);
                    busy_next  = !dx_zero || (dy_abs != '0);
                end
            end
        end
        else if (!busy_reg)
        begin
            rsp_data_next.result_kind = KIND_IDLE;
        end
        else
        begin
            rsp_data_next.result_kind = KIND_STEP;
            if (vpend_reg)
            begin
                // vertical step: one whole divisor out of the accumulator
                if (y_neg_reg)
                begin
                    rsp_data_next.step_dir = DIR_DOWN;
                    cur_y_next             = cur_y_reg - 1'b1;
                end
                else
                begin
                    rsp_data_next.step_dir = DIR_UP;
                    cur_y_next             = cur_y_reg + 1'b1;
                end
                acc_next = acc_reg - {1'b0, div_reg};
            end
            else
            begin
                // horizontal step: next column, add dy to the accumulator
                if (x_neg_reg)
                begin
                    rsp_data_next.step_dir = DIR_LEFT;
                    cur_x_next             = cur_x_reg - 1'b1;
                end
                else
                begin
                    rsp_data_next.step_dir = DIR_RIGHT;
                    cur_x_next             = cur_x_reg + 1'b1;
                end
                cols_next = cols_reg - 1'b1;
                acc_next  = acc_reg + {1'b0, dy_reg};
            end
            vpend_next = (acc_next >= {1'b0, div_reg});
            if (!vpend_next && (cols_next == '0))
            begin
                busy_next               = 1'b0;
                rsp_data_next.move_done = 1'b1;
            end
        end

        rsp_data_next.pen_state_out = pen_next;
        rsp_data_next.pos_x         = cur_x_next;
        rsp_data_next.pos_y         = cur_y_next;
    end

    assign rsp_valid_next = take || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            pen_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            dy_reg        <= '0;
            div_reg       <= '0;
            cols_reg      <= '0;
            acc_reg       <= '0;
            vpend_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (take)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                pen_reg   <= pen_next;
                busy_reg  <= busy_next;
                x_neg_reg <= x_neg_next;
                y_neg_reg <= y_neg_next;
                dy_reg    <= dy_next;
                div_reg   <= div_next;
                cols_reg  <= cols_next;
                acc_reg   <= acc_next;
                vpend_reg <= vpend_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // busy exactly while work is left
    a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == ((cols_reg != '0) || vpend_reg))
        else $error("busy flag out of step with remaining work");

    // a finished move leaves the stepper idle while its result waits
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.move_done)
            |-> (!busy_reg && (rsp_data_reg.result_kind == KIND_STEP)))
        else $error("move done without idle stepper");

    // servo commands only come from move requests that were not busy
    a_servo_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.servo_cmd)
            |-> ((rsp_data_reg.result_kind == KIND_ACCEPTED)
                 || (rsp_data_reg.result_kind == KIND_RANGE)))
        else $error("servo command on a wrong result kind");

    // a step moves the position by exactly one unit on one axis
    a_unit_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && head_cmd.is_tick && busy_reg)
            |=> ((cur_x_reg != $past(cur_x_reg)) != (cur_y_reg != $past(cur_y_reg))))
        else $error("step did not move exactly one axis");

endmodule

// ----- hdl/plotter_line_stepper.sv -----
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+----------------------------------------
// request   | req_valid | req_stall | req_data  (move request or tick)
// response  | rsp_valid | rsp_stall | rsp_data  (one result per request)
// config    | cfg_wen   | -         | cfg_index, cfg_data  (max_x, max_y)
//
// one request per cycle sustained while req_stall is low; a request is written into a
// queue entry at its transfer, and the execute stage, which does one add and compare
// per step, takes it from the queue head and registers its result in the result register
// reset: position at the origin, pen up, stepper idle, both limits at their maximum
// req_stall rises only when the queue between front and back is full; a stalled
// response holds the back end, and the queue absorbs QUEUE_DEPTH more requests
module plotter_line_stepper #(
    parameter int QUEUE_DEPTH = pls_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [pls_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [pls_pkg::POS_BITS-1:0]      cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  pls_pkg::in_item_t                 req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output pls_pkg::out_item_t                rsp_data
);
    import pls_pkg::*;

    logic push_valid;
    cmd_t push_cmd;
    logic queue_full;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    // front: limits and classification
    pls_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_data   (req_data),
        .queue_full (queue_full),
        .req_stall  (req_stall),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    // queue between front and back
    pls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // back: motion state and result register
    pls_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

endmodule

// ----- tb/tb.sv -----
module tb;
    import pls_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 300;
    localparam int PHASES        = 7;

    typedef struct {
        logic      fixed;
        out_item_t rsp;
    } pin_t;

    typedef struct {
        in_item_t  req;
        logic      fixed;
        out_item_t rsp;
        int        ticks;
    } row_t;

    typedef enum int {STALL_NONE, STALL_THIRD, STALL_COIN, STALL_HOLD} stall_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wen = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_MAX_X;
    logic [POS_BITS-1:0]     cfg_data = '0;
    logic                    req_valid = 1'b0;
    logic                    req_stall;
    in_item_t                req_data = '0;
    logic                    rsp_valid;
    logic                    rsp_stall = 1'b0;
    out_item_t               rsp_data;

    // stepper state mirrored for prediction
    logic [POS_BITS-1:0] lim_x = '1;
    logic [POS_BITS-1:0] lim_y = '1;
    logic [POS_BITS-1:0] m_x = '0;
    logic [POS_BITS-1:0] m_y = '0;
    logic                m_pen = 1'b0;
    logic                m_busy = 1'b0;
    logic                m_xneg = 1'b0;
    logic                m_yneg = 1'b0;
    int unsigned         m_adx = 0;
    int unsigned         m_ady = 0;
    int unsigned         m_cols = 0;
    int unsigned         m_acc = 0;
    int unsigned         m_vert = 0;

    out_item_t   pending_results[$];
    pin_t        table_answers[$];
    row_t        step_table[$];
    int          mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int          burst_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;
    int unsigned stall_tick = 0;

    plotter_line_stepper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("** plotter_line_stepper: FAILED **");
            $finish;
        end
    end

    function automatic in_item_t mk_req(logic rt, logic [15:0] tx, logic [15:0] ty, logic pen);
        in_item_t it;
        it.req_type = rt;
        it.target_x = tx;
        it.target_y = ty;
        it.pen_down = pen;
        return it;
    endfunction

    function automatic out_item_t mk_rsp(logic [2:0] kind, logic [1:0] dir, logic servo,
                                         logic pen, logic [POS_BITS-1:0] x,
                                         logic [POS_BITS-1:0] y, logic done);
        out_item_t r;
        r.result_kind   = kind;
        r.step_dir      = dir;
        r.servo_cmd     = servo;
        r.pen_state_out = pen;
        r.pos_x         = x;
        r.pos_y         = y;
        r.move_done     = done;
        return r;
    endfunction

    // advance the mirrored stepper by one request and return its result
    function automatic out_item_t next_plotter_result(in_item_t it);
        int        tx;
        int        ty;
        int        dx;
        int        dy;
        logic      servo;
        logic [1:0] dir;
        logic      done;
        servo = 1'b0;
        dir   = DIR_UP;
        done  = 1'b0;
        if (it.req_type == REQ_MOVE)
        begin
            if (m_busy)
                return mk_rsp(KIND_BUSY, DIR_UP, 1'b0, m_pen, m_x, m_y, 1'b0);
            // pen follows the request even when the target is rejected
            if (it.pen_down != m_pen)
            begin
                servo = 1'b1;
                m_pen = it.pen_down;
            end
            tx = $signed(it.target_x);
            ty = $signed(it.target_y);
            if (tx < 0 || ty < 0 || tx > int'(lim_x) || ty > int'(lim_y))
                return mk_rsp(KIND_RANGE, DIR_UP, servo, m_pen, m_x, m_y, 1'b0);
            dx     = tx - int'(m_x);
            dy     = ty - int'(m_y);
            m_xneg = (dx < 0);
            m_yneg = (dy < 0);
            m_adx  = (dx < 0) ? -dx : dx;
            m_ady  = (dy < 0) ? -dy : dy;
            m_acc  = 0;
            if (m_adx == 0)
            begin
                m_cols = 0;
                m_vert = m_ady;
            end
            else
            begin
                m_cols = m_adx;
                m_vert = 0;
            end
            m_busy = (m_cols != 0 || m_vert != 0);
            return mk_rsp(KIND_ACCEPTED, DIR_UP, servo, m_pen, m_x, m_y, 1'b0);
        end
        if (!m_busy)
            return mk_rsp(KIND_IDLE, DIR_UP, 1'b0, m_pen, m_x, m_y, 1'b0);
        // vertical catch-up first, then the next column
        if (m_vert != 0)
        begin
            if (m_yneg)
            begin
                dir = DIR_DOWN;
                m_y = m_y - 1'b1;
            end
            else
            begin
                dir = DIR_UP;
                m_y = m_y + 1'b1;
            end
            m_vert--;
        end
        else if (m_cols != 0)
        begin
            if (m_xneg)
            begin
                dir = DIR_LEFT;
                m_x = m_x - 1'b1;
            end
            else
            begin
                dir = DIR_RIGHT;
                m_x = m_x + 1'b1;
            end
            m_cols--;
            m_acc  = m_acc + m_ady;
            m_vert = m_acc / m_adx;
            m_acc  = m_acc % m_adx;
        end
        if (m_vert == 0 && m_cols == 0)
        begin
            m_busy = 1'b0;
            done   = 1'b1;
        end
        return mk_rsp(KIND_STEP, dir, 1'b0, m_pen, m_x, m_y, done);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_cnt < 50)
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_cnt++;
    endtask

    // predict on request transfer, check on response transfer
    always @(posedge clk)
    begin : scoreboard
        pin_t      pin;
        out_item_t pred;
        out_item_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                pred = next_plotter_result(req_data);
                pin  = table_answers.pop_front();
                pending_results.push_back(pin.fixed ? pin.rsp : pred);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", rsp_data.result_kind, -1);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_data.result_kind !== want.result_kind)
                        report_mismatch("result_kind", rsp_data.result_kind, want.result_kind);
                    if (rsp_data.step_dir !== want.step_dir)
                        report_mismatch("step_dir", rsp_data.step_dir, want.step_dir);
                    if (rsp_data.servo_cmd !== want.servo_cmd)
                        report_mismatch("servo_cmd", rsp_data.servo_cmd, want.servo_cmd);
                    if (rsp_data.pen_state_out !== want.pen_state_out)
                        report_mismatch("pen_state_out", rsp_data.pen_state_out,
                                        want.pen_state_out);
                    if (rsp_data.pos_x !== want.pos_x)
                        report_mismatch("pos_x", rsp_data.pos_x, want.pos_x);
                    if (rsp_data.pos_y !== want.pos_y)
                        report_mismatch("pos_y", rsp_data.pos_y, want.pos_y);
                    if (rsp_data.move_done !== want.move_done)
                        report_mismatch("move_done", rsp_data.move_done, want.move_done);
                end
            end
        end
    end

    // response stall pattern, changing mode every stretch
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_THIRD: rsp_stall <= (stall_tick % 3 == 0);
            STALL_COIN:  rsp_stall <= 1'($urandom_range(0, 1));
            default:     rsp_stall <= (stall_tick % 8) < 6;
        endcase
    end

    // one request transfer, with bursts and gaps on the sender side
    task automatic send_req(in_item_t it, logic fixed, out_item_t want);
        pin_t pin;
        int   gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 200)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        pin.fixed = fixed;
        pin.rsp   = want;
        table_answers.push_back(pin);
        req_valid <= 1'b1;
        req_data  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic send_tick();
        send_req(mk_req(REQ_TICK, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1))), 1'b0, '0);
    endtask

    // hold off until every result is back and the pipeline has emptied
    task automatic wait_quiet();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(logic [POS_BITS-1:0] lx, logic [POS_BITS-1:0] ly);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_MAX_X;
        cfg_data  <= lx;
        @(posedge clk);
        cfg_index <= CFG_MAX_Y;
        cfg_data  <= ly;
        @(posedge clk);
        cfg_wen <= 1'b0;
        lim_x = lx;
        lim_y = ly;
    endtask

    task automatic add_row(logic rt, logic [15:0] tx, logic [15:0] ty, logic pen,
                           logic fixed, out_item_t want, int ticks);
        row_t row;
        row.req   = mk_req(rt, tx, ty, pen);
        row.fixed = fixed;
        row.rsp   = want;
        row.ticks = ticks;
        step_table.push_back(row);
    endtask

    function automatic int pick_coord(int plan, int lim);
        logic signed [15:0] raw;
        int                 r;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            // raw pattern kept outside the drawing area so it never starts a long line
            raw = 16'($urandom_range(0, 65535));
            if (!raw[15] && int'(raw) <= lim)
                raw[15] = 1'b1;
            return int'(raw);
        end
        if (r < 5 && lim <= 63)
            return $urandom_range(0, lim);
        return plan + int'($urandom_range(0, 24)) - 12;
    endfunction

    initial
    begin
        row_t     row;
        in_item_t mv;
        int       phase_lx[PHASES];
        int       phase_ly[PHASES];
        int       budget;
        int       sent;
        int       plan_x;
        int       plan_y;
        int       tx;
        int       ty;
        int       total;
        int       brk;

        phase_lx = '{0, 15, 63, 1, 32767, 300, 20};
        phase_ly = '{0, 15, 7, 200, 32767, 40, 63};

        // directed rows at the reset limits
        add_row(REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1,
                mk_rsp(KIND_IDLE, DIR_UP, 1'b0, 1'b0, 0, 0, 1'b0), 0);
        add_row(REQ_MOVE, 16'h0000, 16'h0000, 1'b0, 1'b1,
                mk_rsp(KIND_ACCEPTED, DIR_UP, 1'b0, 1'b0, 0, 0, 1'b0), 0);
        add_row(REQ_MOVE, 16'h8000, 16'h0005, 1'b1, 1'b1,
                mk_rsp(KIND_RANGE, DIR_UP, 1'b1, 1'b1, 0, 0, 1'b0), 0);
        add_row(REQ_MOVE, 16'h0005, 16'hffff, 1'b1, 1'b1,
                mk_rsp(KIND_RANGE, DIR_UP, 1'b0, 1'b1, 0, 0, 1'b0), 0);
        add_row(REQ_MOVE, 16'h0005, 16'h0002, 1'b0, 1'b1,
                mk_rsp(KIND_ACCEPTED, DIR_UP, 1'b1, 1'b0, 0, 0, 1'b0), 1);
        // move while the line is still running
        add_row(REQ_MOVE, 16'hffff, 16'hffff, 1'b1, 1'b1,
                mk_rsp(KIND_BUSY, DIR_UP, 1'b0, 1'b0, 1, 0, 1'b0), 6);
        add_row(REQ_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1,
                mk_rsp(KIND_IDLE, DIR_UP, 1'b0, 1'b0, POS_BITS'(5), POS_BITS'(2), 1'b0), 0);
        add_row(REQ_MOVE, 16'hffff, 16'h7fff, 1'b1, 1'b1,
                mk_rsp(KIND_RANGE, DIR_UP, 1'b1, 1'b1, POS_BITS'(5), POS_BITS'(2), 1'b0), 0);
        add_row(REQ_MOVE, 16'h0000, 16'h0000, 1'b1, 1'b0, '0, 7);
        add_row(REQ_MOVE, 16'h0000, 16'h0004, 1'b0, 1'b0, '0, 4);
        add_row(REQ_MOVE, 16'h0000, 16'h0000, 1'b1, 1'b0, '0, 4);
        add_row(REQ_MOVE, 16'h0003, 16'h0007, 1'b1, 1'b0, '0, 10);
        add_row(REQ_MOVE, 16'h0000, 16'h0000, 1'b0, 1'b0, '0, 10);
        add_row(REQ_MOVE, 16'h0007, 16'h0003, 1'b1, 1'b0, '0, 10);
        add_row(REQ_MOVE, 16'h0002, 16'h0009, 1'b1, 1'b0, '0, 11);
        // tick fields are don't-care
        add_row(REQ_TICK, 16'hffff, 16'h8000, 1'b1, 1'b0, '0, 0);
        add_row(REQ_MOVE, 16'h0004, 16'h0009, 1'b0, 1'b0, '0, 2);
        add_row(REQ_MOVE, 16'h0002, 16'h0009, 1'b0, 1'b0, '0, 2);

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        while (step_table.size() != 0)
        begin
            row = step_table.pop_front();
            send_req(row.req, row.fixed, row.rsp);
            repeat (row.ticks) send_tick();
        end

        // random part: mostly complete lines with random targets
        budget = RANDOM_ITEMS / PHASES;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_quiet();
            write_limits(POS_BITS'(phase_lx[ph]), POS_BITS'(phase_ly[ph]));
            plan_x = m_x;
            plan_y = m_y;
            sent   = 0;
            while (sent < budget)
            begin
                mv = mk_req(REQ_MOVE, 16'(pick_coord(plan_x, lim_x)),
                            16'(pick_coord(plan_y, lim_y)), 1'($urandom_range(0, 1)));
                send_req(mv, 1'b0, '0);
                sent++;
                tx = $signed(mv.target_x);
                ty = $signed(mv.target_y);
                if (tx >= 0 && ty >= 0 && tx <= int'(lim_x) && ty <= int'(lim_y))
                begin
                    total = ((tx > plan_x) ? tx - plan_x : plan_x - tx)
                          + ((ty > plan_y) ? ty - plan_y : plan_y - ty);
                    brk = 0;
                    if (total > 0 && $urandom_range(0, 7) == 0)
                        brk = $urandom_range(1, total);
                    plan_x = tx;
                    plan_y = ty;
                    for (int k = 1; k <= total; k++)
                    begin
                        // broken line: a move lands in the middle of the steps
                        if (k == brk)
                        begin
                            send_req(mk_req(REQ_MOVE, 16'($urandom_range(0, 65535)),
                                            16'($urandom_range(0, 65535)),
                                            1'($urandom_range(0, 1))),
                                     1'b0, '0);
                            sent++;
                        end
                        send_tick();
                        sent++;
                    end
                end
                if ($urandom_range(0, 3) == 0)
                    send_tick();
                if ($urandom_range(0, 24) == 0)
                    wait_quiet();
            end
        end

        // drain and finish
        wait_quiet();
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("** plotter_line_stepper: PASSED **");
        else
            $display("** plotter_line_stepper: FAILED **");
        $finish;
    end

endmodule

// ----- plotter_line_stepper.f -----
hdl/pls_pkg.sv
hdl/pls_front.sv
hdl/pls_queue.sv
hdl/pls_back.sv
hdl/plotter_line_stepper.sv
tb/tb.sv
